### src/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BBPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbpe assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BBPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbpe assertion failed");

`endif

### src/bbpe_pkg.sv
package bbpe_pkg;

    // Stored width of one control point coordinate (signed Q.8).
    localparam int COORD_WIDTH = 16;
    localparam int POINT_COUNT = 16;
    localparam int IDX_W       = $clog2(POINT_COUNT);
    localparam int PARAM_W     = 16;
    localparam int SURF_W      = 24;

    // Basis weights are signed Q.15 after rounding from Q.42.
    localparam int WEIGHT_W     = 25;
    localparam int WEIGHT_SHIFT = 27;
    localparam int FINAL_SHIFT  = 30;
    localparam int ONE_Q14      = 16384;

    localparam int SURF_MAX = 8388607;
    localparam int SURF_MIN = -8388608;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } func_t;

    typedef struct packed {
        func_t                   func;
        logic [IDX_W-1:0]        point_index;
        logic signed [15:0]      point_x;
        logic signed [15:0]      point_y;
        logic signed [15:0]      point_z;
        logic [PARAM_W-1:0]      u_coord;
        logic [PARAM_W-1:0]      v_coord;
    } cmd_t;

    typedef struct packed {
        logic signed [SURF_W-1:0] surf_x;
        logic signed [SURF_W-1:0] surf_y;
        logic signed [SURF_W-1:0] surf_z;
    } result_t;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef weight_t [3:0] weight_vec_t;

    typedef struct packed {
        logic        done;
        weight_vec_t w;
    } basis_res_t;

endpackage

### src/bbpe_ram.sv
module bbpe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/bbpe_basis.sv
module bbpe_basis (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [bbpe_pkg::PARAM_W-1:0]  t_code,
    output bbpe_pkg::basis_res_t          res
);

    localparam logic [2:0] STEP_SS   = 3'd0;
    localparam logic [2:0] STEP_TT   = 3'd1;
    localparam logic [2:0] STEP_SSS  = 3'd2;
    localparam logic [2:0] STEP_SST  = 3'd3;
    localparam logic [2:0] STEP_STT  = 3'd4;
    localparam logic [2:0] STEP_TTT  = 3'd5;
    localparam logic [2:0] STEP_LAST = 3'd6;

    localparam int OP_W  = 18;
    localparam int SQ_W  = 34;
    localparam int MUL_W = SQ_W + OP_W;

    logic                        run_reg;
    logic                        done_reg;
    logic [2:0]                  step_reg;
    logic signed [OP_W-1:0]      t_reg;
    logic signed [OP_W-1:0]      s_reg;
    logic signed [SQ_W-1:0]      sq_s_reg;
    logic signed [SQ_W-1:0]      sq_t_reg;
    logic signed [MUL_W-1:0]     p_reg;
    bbpe_pkg::weight_vec_t       w_reg;

    logic signed [SQ_W-1:0]      op_a;
    logic signed [OP_W-1:0]      op_b;
    logic signed [MUL_W-1:0]     mul;
    logic signed [MUL_W:0]       p_ext;
    logic signed [MUL_W:0]       tri_p;
    logic signed [MUL_W:0]       rnd_one;
    logic signed [MUL_W:0]       rnd_tri;
    bbpe_pkg::weight_t           w_one;
    bbpe_pkg::weight_t           w_tri;

    always_comb
    begin
        case (step_reg)
            STEP_SS:
            begin
                op_a = SQ_W'(s_reg);
                op_b = s_reg;
            end
            STEP_TT:
            begin
                op_a = SQ_W'(t_reg);
                op_b = t_reg;
            end
            STEP_SSS:
            begin
                op_a = sq_s_reg;
                op_b = s_reg;
            end
            STEP_SST:
            begin
                op_a = sq_s_reg;
                op_b = t_reg;
            end
            STEP_STT:
            begin
                op_a = sq_t_reg;
                op_b = s_reg;
            end
            STEP_TTT:
            begin
                op_a = sq_t_reg;
                op_b = t_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        mul = MUL_W'(op_a) * MUL_W'(op_b);
    end

    // Round from Q.42 to Q.15: add half, then take the upper bits (floor).
    always_comb
    begin
        p_ext   = (MUL_W + 1)'(p_reg);
        tri_p   = p_ext + (p_ext <<< 1);
        rnd_one = p_ext + ((MUL_W + 1)'(1) <<< (bbpe_pkg::WEIGHT_SHIFT - 1));
        rnd_tri = tri_p + ((MUL_W + 1)'(1) <<< (bbpe_pkg::WEIGHT_SHIFT - 1));
        w_one   = rnd_one[bbpe_pkg::WEIGHT_SHIFT +: bbpe_pkg::WEIGHT_W];
        w_tri   = rnd_tri[bbpe_pkg::WEIGHT_SHIFT +: bbpe_pkg::WEIGHT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_SS;
        end
        else
        begin
            done_reg <= run_reg && (step_reg == STEP_LAST);
            if (go)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_SS;
            end
            else if (run_reg)
            begin
                if (step_reg == STEP_LAST)
                begin
                    run_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    // The product of one step is registered and consumed in the next.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            t_reg <= $signed({2'b00, t_code});
            s_reg <= $signed(OP_W'(bbpe_pkg::ONE_Q14)) - $signed({2'b00, t_code});
        end
        if (run_reg)
        begin
            p_reg <= mul;
            case (step_reg)
                STEP_TT:   sq_s_reg <= p_reg[SQ_W-1:0];
                STEP_SSS:  sq_t_reg <= p_reg[SQ_W-1:0];
                STEP_SST:  w_reg[0] <= w_one;
                STEP_STT:  w_reg[1] <= w_tri;
                STEP_TTT:  w_reg[2] <= w_tri;
                STEP_LAST: w_reg[3] <= w_one;
                default:   ;
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.w    = w_reg;

endmodule

### src/bicubic_bezier_patch_eval.sv
// Bicubic Bezier patch evaluator. Pulse start with a command while busy is
// low. A load command writes one control point into the patch memory in the
// accepting cycle and gives no result; busy stays low, so a new command may
// follow in the next cycle. An evaluate command raises busy while the two
// basis units, one multiplier each, run their seven steps for u and v, then
// while the patch memory is read once per control point to feed the
// multiply-accumulate lanes, and while the row and column pipeline drains,
// rounds and saturates. The result is on result, marked by done for exactly
// one cycle, in the first cycle that busy is low again; it must be taken
// then, as it cannot be held off. The next command may be accepted at the
// edge that ends that cycle. Reading a point that was never loaded since
// reset gives undefined data.
module bicubic_bezier_patch_eval (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bbpe_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output bbpe_pkg::result_t result
);

    localparam int CW     = bbpe_pkg::COORD_WIDTH;
    localparam int WW     = bbpe_pkg::WEIGHT_W;
    localparam int IW     = bbpe_pkg::IDX_W;
    localparam int PROD_W = WW + CW;
    localparam int ROW_W  = PROD_W + 2;
    localparam int SPLIT  = 21;
    localparam int HALF_W = ROW_W - SPLIT;
    localparam int M_W    = WW + HALF_W;
    localparam int ACC_W  = WW + ROW_W + 2;
    localparam int RND_W  = ACC_W - bbpe_pkg::FINAL_SHIFT;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BASIS = 4'b0010,
        ST_READ  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [IW-1:0]           cnt_reg;
    logic                    a_vld_reg;
    logic [IW-1:0]           a_idx_reg;
    logic                    b_vld_reg;
    logic [IW-1:0]           b_idx_reg;
    logic                    c_lo_reg;
    logic                    c_hi_reg;
    logic [1:0]              c_row_reg;
    logic                    d_vld_reg;
    logic                    d_hi_reg;
    logic                    d_last_reg;
    logic                    fin_reg;
    logic                    done_reg;
    bbpe_pkg::result_t       result_reg;

    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [ROW_W-1:0]  row_acc_reg [3];
    logic signed [ROW_W-1:0]  row_hold_reg [3];
    logic signed [M_W-1:0]    m_reg [3];
    logic signed [ACC_W-1:0]  acc_reg [3];

    logic                    accept;
    logic                    eval_go;
    logic                    wr_en;
    logic [3*CW-1:0]         wr_data;
    logic [3*CW-1:0]         rd_data;
    bbpe_pkg::basis_res_t    bu_res;
    bbpe_pkg::basis_res_t    bv_res;

    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [ROW_W-1:0]  row_sum [3];
    logic signed [M_W-1:0]    m_next [3];
    logic signed [ACC_W-1:0]  acc_add [3];
    logic signed [ACC_W-1:0]  acc_rnd [3];
    logic signed [RND_W-1:0]  rnd_q [3];
    logic signed [bbpe_pkg::SURF_W-1:0] sat_q [3];

    assign accept  = start && (state_reg == ST_IDLE);
    assign eval_go = accept && (cmd.func == bbpe_pkg::FUNC_EVAL);
    assign wr_en   = accept && (cmd.func == bbpe_pkg::FUNC_LOAD);
    assign wr_data = {CW'(cmd.point_z), CW'(cmd.point_y), CW'(cmd.point_x)};

    bbpe_ram #(
        .WIDTH (3 * CW),
        .DEPTH (bbpe_pkg::POINT_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cmd.point_index),
        .wr_data (wr_data),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    bbpe_basis u_basis_u (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (eval_go),
        .t_code (cmd.u_coord),
        .res    (bu_res)
    );

    bbpe_basis u_basis_v (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (eval_go),
        .t_code (cmd.v_coord),
        .res    (bv_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_go)
                begin
                    state_next = ST_BASIS;
                end
            end
            ST_BASIS:
            begin
                if (bu_res.done && bv_res.done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cnt_reg == IW'(bbpe_pkg::POINT_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (fin_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Per coordinate lane: column product, row sum, row weighting split into
    // low and high halves, and the final round and saturate.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod_next[j] = PROD_W'($signed(bu_res.w[a_idx_reg[1:0]]))
                         * PROD_W'($signed(rd_data[j*CW +: CW]));
            if (b_idx_reg[1:0] == 2'd0)
            begin
                row_sum[j] = ROW_W'(prod_reg[j]);
            end
            else
            begin
                row_sum[j] = row_acc_reg[j] + ROW_W'(prod_reg[j]);
            end
            if (c_hi_reg)
            begin
                m_next[j] = M_W'($signed(bv_res.w[c_row_reg]))
                          * M_W'($signed(row_hold_reg[j][ROW_W-1:SPLIT]));
            end
            else
            begin
                m_next[j] = M_W'($signed(bv_res.w[c_row_reg]))
                          * M_W'($signed({1'b0, row_hold_reg[j][SPLIT-1:0]}));
            end
            if (d_hi_reg)
            begin
                acc_add[j] = ACC_W'(m_reg[j]) <<< SPLIT;
            end
            else
            begin
                acc_add[j] = ACC_W'(m_reg[j]);
            end
            acc_rnd[j] = acc_reg[j]
                       + (ACC_W'(1) <<< (bbpe_pkg::FINAL_SHIFT - 1));
            rnd_q[j]   = acc_rnd[j][ACC_W-1:bbpe_pkg::FINAL_SHIFT];
            if (rnd_q[j] > RND_W'(bbpe_pkg::SURF_MAX))
            begin
                sat_q[j] = bbpe_pkg::SURF_W'(bbpe_pkg::SURF_MAX);
            end
            else if (rnd_q[j] < RND_W'(bbpe_pkg::SURF_MIN))
            begin
                sat_q[j] = bbpe_pkg::SURF_W'(bbpe_pkg::SURF_MIN);
            end
            else
            begin
                sat_q[j] = rnd_q[j][bbpe_pkg::SURF_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_lo_reg   <= 1'b0;
            c_hi_reg   <= 1'b0;
            d_vld_reg  <= 1'b0;
            d_hi_reg   <= 1'b0;
            d_last_reg <= 1'b0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
            begin
                cnt_reg <= cnt_reg + IW'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
            a_vld_reg  <= (state_reg == ST_READ);
            b_vld_reg  <= a_vld_reg;
            c_lo_reg   <= b_vld_reg && (b_idx_reg[1:0] == 2'd3);
            c_hi_reg   <= c_lo_reg;
            d_vld_reg  <= c_lo_reg || c_hi_reg;
            d_hi_reg   <= c_hi_reg;
            d_last_reg <= c_hi_reg && (c_row_reg == 2'd3);
            fin_reg    <= d_vld_reg && d_last_reg;
            done_reg   <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg <= cnt_reg;
        b_idx_reg <= a_idx_reg;
        if (b_vld_reg && (b_idx_reg[1:0] == 2'd3))
        begin
            c_row_reg <= b_idx_reg[3:2];
        end
        for (int j = 0; j < 3; j++)
        begin
            if (a_vld_reg)
            begin
                prod_reg[j] <= prod_next[j];
            end
            if (b_vld_reg)
            begin
                row_acc_reg[j] <= row_sum[j];
                if (b_idx_reg[1:0] == 2'd3)
                begin
                    row_hold_reg[j] <= row_sum[j];
                end
            end
            if (c_lo_reg || c_hi_reg)
            begin
                m_reg[j] <= m_next[j];
            end
            if (eval_go)
            begin
                acc_reg[j] <= '0;
            end
            else if (d_vld_reg)
            begin
                acc_reg[j] <= acc_reg[j] + acc_add[j];
            end
        end
        if (fin_reg)
        begin
            result_reg.surf_x <= sat_q[0];
            result_reg.surf_y <= sat_q[1];
            result_reg.surf_z <= sat_q[2];
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### src/bbpe_checker.sv
`include "assert_macros.svh"

module bbpe_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input bbpe_pkg::cmd_t    cmd,
    input logic              busy,
    input logic              done,
    input bbpe_pkg::result_t result
);

    logic eval_accept;
    logic load_accept;

    assign eval_accept = start && !busy && (cmd.func == bbpe_pkg::FUNC_EVAL);
    assign load_accept = start && !busy && (cmd.func == bbpe_pkg::FUNC_LOAD);

    // A result transfer only appears once the evaluation has finished, with known data.
    `BBPE_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy && !$isunknown(result))
    // An evaluation holds the block busy from the next cycle on.
    `BBPE_ASSERT_NEXT(a_eval_busy, clk, rst_n, eval_accept, busy && !done)
    // A load completes at once and never produces a result.
    `BBPE_ASSERT_NEXT(a_load_quiet, clk, rst_n, load_accept, !busy && !done)
    // Busy falls exactly when the result transfer is shown.
    `BBPE_ASSERT_SAME(a_fall_done, clk, rst_n, $fell(busy), done)
    // The strobe lasts a single cycle.
    `BBPE_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)

endmodule

bind bicubic_bezier_patch_eval bbpe_checker u_bbpe_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
);
